>>> hdl/cror_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cror_pkg
// Shared types, constants and helpers for the coverage ramp / over blender.
// ----------------------------------------------------------------------------
package cror_pkg;

   localparam int unsigned CHAN_COUNT = 3;
   localparam int unsigned DIV_CELLS  = 8;

   localparam logic [7:0] TRANSL_FULL       = 8'd255;
   localparam logic [7:0] TRANSL_SELECT_MIN = 8'd204;
   localparam logic [7:0] LEVEL_MAX         = 8'd255;

   typedef logic [CHAN_COUNT-1:0][7:0] color_type;

   typedef struct packed {
      logic [CHAN_COUNT-1:0][23:0] rem;
      logic [CHAN_COUNT-1:0][7:0]  quo;
      logic [15:0]                 den;
      logic                        den_zero;
      color_type                   ramp;
      logic [7:0]                  alpha;
   } cror_div_type;

   // Floor of x / 255, exact for x up to 65025.
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] s;
      s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      return s[15:8];
   endfunction

endpackage

>>> hdl/cror_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cror_front
// Two-stage front end: translucency, products, ramp colors, combined alpha,
// and the over numerators and denominator handed to the divider chain.
// ----------------------------------------------------------------------------
module cror_front import cror_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         up_valid,
   output logic         up_ready,
   input  color_type    up_fg,
   input  color_type    up_bg,
   input  logic [7:0]   up_coverage,
   input  logic         up_selected,
   input  logic         up_full_opaque,
   input  logic [7:0]   base_transl,
   output logic         dn_valid,
   input  logic         dn_ready,
   output cror_div_type dn_data
);

   logic                        a_valid_ff;
   logic [CHAN_COUNT-1:0][15:0] a_fi_ff;
   logic [CHAN_COUNT-1:0][15:0] a_bj_ff;
   logic [15:0]                 a_tw_ff;
   logic [7:0]                  a_cov_ff;
   color_type                   a_bg_ff;
   logic                        b_valid_ff;
   cror_div_type                b_data_ff;

   logic                        a_ready;
   logic                        b_ready;
   logic [8:0]                  sel_sum;
   logic [7:0]                  sel_t;
   logic [7:0]                  transl;
   logic [7:0]                  inv_cov;
   logic [CHAN_COUNT-1:0][15:0] fi_in;
   logic [CHAN_COUNT-1:0][15:0] bj_in;
   logic [15:0]                 tw_in;
   logic [15:0]                 den;
   cror_div_type                b_data_in;

   assign b_ready  = !b_valid_ff || dn_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign up_ready = a_ready;
   assign dn_valid = b_valid_ff;
   assign dn_data  = b_data_ff;

   always_comb begin
      sel_sum = {1'b0, base_transl} + {1'b0, TRANSL_FULL};
      sel_t   = (sel_sum[8:1] < TRANSL_SELECT_MIN) ? TRANSL_SELECT_MIN : sel_sum[8:1];
      priority if (up_full_opaque) begin
         transl = TRANSL_FULL;
      end else if (up_selected) begin
         transl = sel_t;
      end else begin
         transl = base_transl;
      end
      inv_cov = LEVEL_MAX - up_coverage;
      for (int k = 0; k < CHAN_COUNT; k++) begin
         fi_in[k] = 16'(up_fg[k]) * 16'(up_coverage);
         bj_in[k] = 16'(up_bg[k]) * 16'(inv_cov);
      end
      tw_in = 16'(transl) * 16'(inv_cov);
   end

   always_comb begin
      den = {a_cov_ff, 8'h00} - {8'h00, a_cov_ff} + a_tw_ff;
      b_data_in.den      = den;
      b_data_in.den_zero = (den == 16'd0);
      b_data_in.alpha    = div255(den);
      b_data_in.quo      = '0;
      for (int k = 0; k < CHAN_COUNT; k++) begin
         b_data_in.ramp[k] = div255(a_fi_ff[k] + a_bj_ff[k]);
         b_data_in.rem[k]  = {a_fi_ff[k], 8'h00} - {8'h00, a_fi_ff[k]}
                           + 24'(a_bg_ff[k]) * 24'(a_tw_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= up_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && up_valid) begin
         a_fi_ff  <= fi_in;
         a_bj_ff  <= bj_in;
         a_tw_ff  <= tw_in;
         a_cov_ff <= up_coverage;
         a_bg_ff  <= up_bg;
      end
      if (b_ready && a_valid_ff) begin
         b_data_ff <= b_data_in;
      end
   end

endmodule

>>> hdl/cror_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cror_div_cell
// One restoring division cell: settles one quotient bit for each color
// lane and hands the partial remainder on to the next cell.
// ----------------------------------------------------------------------------
module cror_div_cell import cror_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         up_valid,
   output logic         up_ready,
   input  cror_div_type up_data,
   output logic         dn_valid,
   input  logic         dn_ready,
   output cror_div_type dn_data
);

   logic         valid_ff;
   cror_div_type data_ff;
   cror_div_type data_in;
   logic [23:0]  divisor;
   logic [CHAN_COUNT-1:0][23:0] diff;
   logic [CHAN_COUNT-1:0]       take;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_comb begin
      data_in = up_data;
      divisor = {1'b0, up_data.den, 7'd0};
      for (int k = 0; k < CHAN_COUNT; k++) begin
         take[k] = (up_data.rem[k] >= divisor);
         diff[k] = take[k] ? (up_data.rem[k] - divisor) : up_data.rem[k];
         data_in.rem[k] = {diff[k][22:0], 1'b0};
         data_in.quo[k] = {up_data.quo[k][6:0], take[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> hdl/coverage_ramp_over_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coverage_ramp_over_blend
// Blends a foreground over a background color two ways per request: an
// opaque linear ramp by coverage and a non-premultiplied over with alpha.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel req_*: foreground and background RGB, coverage and the
//    selected / full_opaque flags. Taken when req_valid is high and
//    req_stall is low.
//  - Response channel rsp_*: ramp RGB, over RGB and over alpha. Taken when
//    rsp_valid is high and rsp_stall is low.
//  - CSR channel csr_*: writes the base translucency; csr_ready is always
//    high. Write it only while no request is in flight.
//  - Pipeline: a request passes two front stages (products, then sums and
//    the over numerators) and a chain of eight divider cells, one quotient
//    bit per cell.
//  - Throughput: one request per cycle while rsp_stall stays low.
//  - Each stage holds its request when the one after it is full and cannot
//    pass its own on, so a stalled response stops only the stages behind it;
//    req_stall rises once every stage is occupied and rsp_stall is high.
//  - Reset empties the pipeline and sets the base translucency to 255.
// ----------------------------------------------------------------------------
module coverage_ramp_over_blend import cror_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_fg_red,
   input  logic [7:0] req_fg_green,
   input  logic [7:0] req_fg_blue,
   input  logic [7:0] req_bg_red,
   input  logic [7:0] req_bg_green,
   input  logic [7:0] req_bg_blue,
   input  logic [7:0] req_coverage,
   input  logic       req_selected,
   input  logic       req_full_opaque,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_ramp_red,
   output logic [7:0] rsp_ramp_green,
   output logic [7:0] rsp_ramp_blue,
   output logic [7:0] rsp_over_red,
   output logic [7:0] rsp_over_green,
   output logic [7:0] rsp_over_blue,
   output logic [7:0] rsp_over_alpha,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   logic [7:0]   base_ff;
   logic [7:0]   base_in;
   logic         front_ready;
   logic         stage_valid [0:DIV_CELLS];
   logic         stage_ready [0:DIV_CELLS];
   cror_div_type stage_data  [0:DIV_CELLS];
   cror_div_type last;

   assign csr_ready = 1'b1;
   assign base_in   = csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= TRANSL_FULL;
      end else if (csr_valid && csr_ready) begin
         base_ff <= base_in;
      end
   end

   cror_front u_front (
      .clock          (clock),
      .reset          (reset),
      .up_valid       (req_valid),
      .up_ready       (front_ready),
      .up_fg          ({req_fg_blue, req_fg_green, req_fg_red}),
      .up_bg          ({req_bg_blue, req_bg_green, req_bg_red}),
      .up_coverage    (req_coverage),
      .up_selected    (req_selected),
      .up_full_opaque (req_full_opaque),
      .base_transl    (base_ff),
      .dn_valid       (stage_valid[0]),
      .dn_ready       (stage_ready[0]),
      .dn_data        (stage_data[0])
   );

   for (genvar g = 0; g < DIV_CELLS; g++) begin : g_cell
      cror_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stage_valid[g]),
         .up_ready (stage_ready[g]),
         .up_data  (stage_data[g]),
         .dn_valid (stage_valid[g+1]),
         .dn_ready (stage_ready[g+1]),
         .dn_data  (stage_data[g+1])
      );
   end

   assign req_stall              = !front_ready;
   assign stage_ready[DIV_CELLS] = !rsp_stall;
   assign rsp_valid              = stage_valid[DIV_CELLS];
   assign last                   = stage_data[DIV_CELLS];

   assign rsp_ramp_red   = last.ramp[0];
   assign rsp_ramp_green = last.ramp[1];
   assign rsp_ramp_blue  = last.ramp[2];
   assign rsp_over_red   = last.den_zero ? 8'd0 : last.quo[0];
   assign rsp_over_green = last.den_zero ? 8'd0 : last.quo[1];
   assign rsp_over_blue  = last.den_zero ? 8'd0 : last.quo[2];
   assign rsp_over_alpha = last.den_zero ? 8'd0 : last.alpha;

`ifndef SYNTHESIS
   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with an empty output stage");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   a_zero_alpha_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_over_alpha == 8'd0 |->
         rsp_over_red == 8'd0 && rsp_over_green == 8'd0 && rsp_over_blue == 8'd0)
      else $error("zero alpha with nonzero over color");

   a_opaque_matches_ramp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_over_alpha == 8'd255 |->
         rsp_over_red == rsp_ramp_red && rsp_over_green == rsp_ramp_green &&
         rsp_over_blue == rsp_ramp_blue)
      else $error("opaque over differs from ramp");
`endif

endmodule
